FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands for the stroke coverage core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock while out of reset
`define SCCT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// condition in one cycle implies a result in the next
`define SCCT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: sv/scct_pkg.sv
// ---------------------------------------------------------------------------
// scct_pkg
// Shared constants, register indexes and types of the stroke coverage core.
// ---------------------------------------------------------------------------
package scct_pkg;

    localparam int HW_BITS      = 16;
    localparam int REG_IDX_BITS = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_CHAR_LEFT   = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_CHAR_TOP    = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_CHAR_RIGHT  = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_CHAR_BOTTOM = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_HALF_WIDTH  = 3'd4;

    // 0.5 pt and 1/64 pt in 1/64 pt units
    localparam int HALF_PT = 32;
    localparam int MARGIN  = 1;

    typedef struct packed {
        logic busy;
        logic done;
    } md_stat_t;

endpackage

FILE: sv/scct_muldiv.sv
// ---------------------------------------------------------------------------
// scct_muldiv
// Bit-serial multiply followed by restoring divide on one shared accumulator:
// quotient = floor(mag_a * mag_b / divisor), quotient below 2^(W+2).
// ---------------------------------------------------------------------------
module scct_muldiv #(
    parameter int W = 18
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [W:0]           mag_a,
    input  logic [W+1:0]         mag_b,
    input  logic [W+1:0]         divisor,
    output logic [W+1:0]         quotient,
    output scct_pkg::md_stat_t   md_stat
);
    import scct_pkg::*;

    localparam int AW   = 2 * W + 4;
    localparam int CNTW = $clog2(W + 3);
    localparam logic [CNTW-1:0] MUL_STEPS = CNTW'(W + 1);
    localparam logic [CNTW-1:0] DIV_STEPS = CNTW'(W + 2);

    logic [AW-1:0]   acc_reg, acc_next;
    logic [W:0]      a_reg, a_next;
    logic [W+1:0]    b_reg, b_next;
    logic [W+1:0]    d_reg, d_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            mul_run_reg, mul_run_next;
    logic            div_run_reg, div_run_next;
    logic            done_reg, done_next;

    logic [W+2:0]    trial;
    logic [W+2:0]    diff;
    logic            fits;
    logic [W+1:0]    rem;
    md_stat_t        stat;

    assign trial = acc_reg[AW-1:W+1];
    assign diff  = trial - {1'b0, d_reg};
    assign fits  = (trial >= {1'b0, d_reg});
    assign rem   = fits ? diff[W+1:0] : trial[W+1:0];

    always_comb begin
        acc_next     = acc_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        d_next       = d_reg;
        cnt_next     = cnt_reg;
        mul_run_next = mul_run_reg;
        div_run_next = div_run_reg;
        done_next    = 1'b0;
        if (start) begin
            acc_next     = '0;
            a_next       = mag_a;
            b_next       = mag_b;
            d_next       = divisor;
            cnt_next     = MUL_STEPS;
            mul_run_next = 1'b1;
        end else if (mul_run_reg) begin
            acc_next = {acc_reg[AW-2:0], 1'b0} + (a_reg[W] ? AW'(b_reg) : '0);
            a_next   = {a_reg[W-1:0], 1'b0};
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1)) begin
                mul_run_next = 1'b0;
                div_run_next = 1'b1;
                cnt_next     = DIV_STEPS;
            end
        end else if (div_run_reg) begin
            acc_next = {rem, acc_reg[W:0], fits};
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1)) begin
                div_run_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            mul_run_reg <= 1'b0;
            div_run_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            mul_run_reg <= mul_run_next;
            div_run_reg <= div_run_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        d_reg   <= d_next;
    end

    assign stat.busy = mul_run_reg | div_run_reg;
    assign stat.done = done_reg;
    assign md_stat   = stat;
    assign quotient  = acc_reg[W+1:0];

endmodule

FILE: sv/scct_band_test.sv
// ---------------------------------------------------------------------------
// scct_band_test
// Overlap of a vertical stroke band with the character core, in quarter units.
// ---------------------------------------------------------------------------
module scct_band_test #(
    parameter int W  = 18,
    parameter int BW = 23
) (
    input  logic signed [BW-1:0] band_top,
    input  logic signed [BW-1:0] band_bot,
    input  logic signed [W-1:0]  box_top,
    input  logic signed [W-1:0]  box_bot,
    output logic                 hit
);
    import scct_pkg::*;

    localparam int TW = BW + 4;
    localparam logic signed [TW-1:0] MARGIN4 = TW'(4 * MARGIN);

    logic signed [TW-1:0] top_e, bot_e, height;
    logic signed [TW-1:0] core_top4, core_bot4;
    logic signed [TW-1:0] band_top4, band_bot4;

    assign top_e     = TW'(box_top);
    assign bot_e     = TW'(box_bot);
    assign height    = bot_e - top_e;
    assign core_top4 = (top_e <<< 2) + height;
    assign core_bot4 = (bot_e <<< 2) + height;
    assign band_top4 = TW'(band_top) <<< 2;
    assign band_bot4 = TW'(band_bot) <<< 2;

    assign hit = (band_bot4 > core_top4 + MARGIN4) && (band_top4 < core_bot4 - MARGIN4);

endmodule

FILE: sv/stroke_covers_char_test_core.sv
// ---------------------------------------------------------------------------
// stroke_covers_char_test_core
// Highlighter stroke versus character box coverage test.
// ---------------------------------------------------------------------------
// Stroke points enter one word at a time; every point after the first closes
// a segment with the point before it, and a word flagged last_point produces
// one covered word telling whether any segment of the stroke reached the box
// core (the box moved down a quarter of its height, less one LSB at top and
// bottom). Coordinates are two's complement in 1/64 pt. A first point goes
// IDLE to FINISH; a segment whose x span misses the box centre adds SETUP, a
// nearly upright one SETUP and TEST, a sloped one SETUP, MUL, YCALC and TEST,
// with a bit-serial multiply and restoring divide interpolating y at the
// centre. A last point also waits while the previous covered word is held
// in the output register. The user must write box and half width via the cfg
// port only while the core is idle (not enforced); an unknown index is dropped.
`include "assert_macros.svh"

module stroke_covers_char_test_core #(
    parameter int COORD_BITS = 18,
    localparam int CFG_BITS =
        (COORD_BITS > scct_pkg::HW_BITS) ? COORD_BITS : scct_pkg::HW_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [scct_pkg::REG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]               cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [COORD_BITS-1:0]      s_point_x,
    input  logic signed [COORD_BITS-1:0]      s_point_y,
    input  logic                              s_last_point,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_covered
);
    import scct_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int EW = W + 4;
    localparam int YW = W + 4;
    localparam int BW = ((YW > HW_BITS + 1) ? YW : HW_BITS + 1) + 1;

    localparam logic signed [EW-1:0] HALF2 = EW'(2 * HALF_PT);
    localparam logic [EW-1:0]        HALF  = EW'(HALF_PT);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SETUP  = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_YCALC  = 3'd3;
    localparam logic [2:0] ST_TEST   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic signed [W-1:0]    box_left_reg, box_left_next;
    logic signed [W-1:0]    box_top_reg, box_top_next;
    logic signed [W-1:0]    box_right_reg, box_right_next;
    logic signed [W-1:0]    box_bot_reg, box_bot_next;
    logic [HW_BITS-1:0]     half_width_reg, half_width_next;
    logic                   have_prev_reg, have_prev_next;
    logic                   hit_seen_reg, hit_seen_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   m_covered_reg, m_covered_next;
    logic signed [W-1:0]    prev_x_reg, prev_x_next;
    logic signed [W-1:0]    prev_y_reg, prev_y_next;
    logic signed [W-1:0]    cur_x_reg, cur_x_next;
    logic signed [W-1:0]    cur_y_reg, cur_y_next;
    logic                   last_reg, last_next;
    logic                   neg_reg, neg_next;
    logic signed [BW-1:0]   band_top_reg, band_top_next;
    logic signed [BW-1:0]   band_bot_reg, band_bot_next;

    logic signed [EW-1:0]   cx2, px_e, py_e, qx_e, qy_e;
    logic signed [EW-1:0]   xmin_e, xmax_e, ymin_e, ymax_e;
    logic signed [EW-1:0]   dx, dy, ex;
    logic [EW-1:0]          adx, ady, aex;
    logic                   span_ok, upright, neg;
    logic signed [BW-1:0]   hw_b;
    logic signed [YW-1:0]   py_y, q_y, y_at;
    logic                   md_start;
    logic [W+1:0]           md_quot;
    md_stat_t               md_stat;
    logic                   band_hit;

    // segment geometry from the previous and current point
    assign cx2    = EW'(box_left_reg) + EW'(box_right_reg);
    assign px_e   = EW'(prev_x_reg);
    assign py_e   = EW'(prev_y_reg);
    assign qx_e   = EW'(cur_x_reg);
    assign qy_e   = EW'(cur_y_reg);
    assign xmin_e = (px_e < qx_e) ? px_e : qx_e;
    assign xmax_e = (px_e < qx_e) ? qx_e : px_e;
    assign ymin_e = (py_e < qy_e) ? py_e : qy_e;
    assign ymax_e = (py_e < qy_e) ? qy_e : py_e;
    assign span_ok = (cx2 >= (xmin_e <<< 1) - HALF2) && (cx2 <= (xmax_e <<< 1) + HALF2);
    assign dx     = qx_e - px_e;
    assign dy     = qy_e - py_e;
    assign ex     = cx2 - (px_e <<< 1);
    assign adx    = dx[EW-1] ? -dx : dx;
    assign ady    = dy[EW-1] ? -dy : dy;
    assign aex    = ex[EW-1] ? -ex : ex;
    assign upright = (adx < HALF);
    assign neg    = dx[EW-1] ^ dy[EW-1] ^ ex[EW-1];
    assign hw_b   = BW'(half_width_reg);

    assign py_y = YW'(prev_y_reg);
    assign q_y  = YW'(md_quot);
    assign y_at = neg_reg ? py_y - q_y : py_y + q_y;

    assign md_start = (state_reg == ST_SETUP) && span_ok && !upright;

    scct_muldiv #(
        .W (W)
    ) u_muldiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (md_start),
        .mag_a    (ady[W:0]),
        .mag_b    (aex[W+1:0]),
        .divisor  ({adx[W:0], 1'b0}),
        .quotient (md_quot),
        .md_stat  (md_stat)
    );

    scct_band_test #(
        .W  (W),
        .BW (BW)
    ) u_band_test (
        .band_top (band_top_reg),
        .band_bot (band_bot_reg),
        .box_top  (box_top_reg),
        .box_bot  (box_bot_reg),
        .hit      (band_hit)
    );

    always_comb begin
        state_next      = state_reg;
        box_left_next   = box_left_reg;
        box_top_next    = box_top_reg;
        box_right_next  = box_right_reg;
        box_bot_next    = box_bot_reg;
        half_width_next = half_width_reg;
        have_prev_next  = have_prev_reg;
        hit_seen_next   = hit_seen_reg;
        m_valid_next    = m_valid_reg;
        m_covered_next  = m_covered_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        last_next       = last_reg;
        neg_next        = neg_reg;
        band_top_next   = band_top_reg;
        band_bot_next   = band_bot_reg;

        if (cfg_we) begin
            unique case (cfg_index)
                REG_CHAR_LEFT:   box_left_next   = cfg_wdata[W-1:0];
                REG_CHAR_TOP:    box_top_next    = cfg_wdata[W-1:0];
                REG_CHAR_RIGHT:  box_right_next  = cfg_wdata[W-1:0];
                REG_CHAR_BOTTOM: box_bot_next    = cfg_wdata[W-1:0];
                REG_HALF_WIDTH:  half_width_next = cfg_wdata[HW_BITS-1:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cur_x_next = s_point_x;
                    cur_y_next = s_point_y;
                    last_next  = s_last_point;
                    state_next = have_prev_reg ? ST_SETUP : ST_FINISH;
                end
            end
            ST_SETUP: begin
                if (!span_ok) begin
                    state_next = ST_FINISH;
                end else if (upright) begin
                    band_top_next = BW'(ymin_e) - hw_b;
                    band_bot_next = BW'(ymax_e) + hw_b;
                    state_next    = ST_TEST;
                end else begin
                    neg_next   = neg;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (md_stat.done) begin
                    state_next = ST_YCALC;
                end
            end
            ST_YCALC: begin
                band_top_next = BW'(y_at) - hw_b;
                band_bot_next = BW'(y_at) + hw_b;
                state_next    = ST_TEST;
            end
            ST_TEST: begin
                if (band_hit) begin
                    hit_seen_next = 1'b1;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!last_reg) begin
                    prev_x_next    = cur_x_reg;
                    prev_y_next    = cur_y_reg;
                    have_prev_next = 1'b1;
                    state_next     = ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_covered_next = hit_seen_reg;
                    prev_x_next    = cur_x_reg;
                    prev_y_next    = cur_y_reg;
                    have_prev_next = 1'b0;
                    hit_seen_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            box_left_reg   <= '0;
            box_top_reg    <= '0;
            box_right_reg  <= '0;
            box_bot_reg    <= '0;
            half_width_reg <= '0;
            have_prev_reg  <= 1'b0;
            hit_seen_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            box_left_reg   <= box_left_next;
            box_top_reg    <= box_top_next;
            box_right_reg  <= box_right_next;
            box_bot_reg    <= box_bot_next;
            half_width_reg <= half_width_next;
            have_prev_reg  <= have_prev_next;
            hit_seen_reg   <= hit_seen_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_covered_reg <= m_covered_next;
        prev_x_reg    <= prev_x_next;
        prev_y_reg    <= prev_y_next;
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        last_reg      <= last_next;
        neg_reg       <= neg_next;
        band_top_reg  <= band_top_next;
        band_bot_reg  <= band_bot_next;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_covered = m_covered_reg;

    `SCCT_ASSERT(a_hit_needs_stroke, hit_seen_reg |-> have_prev_reg, "hit flag outside a stroke")
    `SCCT_ASSERT(a_md_done_in_mul, md_stat.done |-> (state_reg == ST_MUL), "divider done out of turn")
    `SCCT_ASSERT(a_out_from_last, $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH && last_reg), "word without last point")
    `SCCT_ASSERT_NEXT(a_first_point_skip, s_valid && s_ready && !have_prev_reg, state_reg == ST_FINISH, "first point started a segment")

endmodule

FILE: tb/stroke_cover_checker.sv
// ---------------------------------------------------------------------------
// stroke_cover_checker
// Watches the stroke coverage core's ports and checks every covered word.
// ---------------------------------------------------------------------------
// Mirrors the box and half width from the cfg port, follows each accepted
// stroke point, and works out at every last point whether any segment of the
// stroke reached the box core. Covered words leaving the core are compared in
// order against these expectations; mismatches, unexpected words and words
// still due are summed into fail_count.
module stroke_cover_checker #(
    parameter int COORD_BITS = 18,
    parameter int CFG_BITS   = 18
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [scct_pkg::REG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]               cfg_wdata,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic signed [COORD_BITS-1:0]      s_point_x,
    input  logic signed [COORD_BITS-1:0]      s_point_y,
    input  logic                              s_last_point,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic                              m_covered,
    output int                                fail_count,
    output int                                pending
);
    import scct_pkg::*;

    longint box_l, box_t, box_r, box_b, half_w;
    longint prev_x, prev_y;
    bit     have_prev, hit_seen;
    bit     covered_due[$];
    int     mismatch_cnt;

    function automatic longint abs_l(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic bit band_hits_core(longint band_top, longint band_bot);
        longint h;
        longint core_top4;
        longint core_bot4;
        h         = box_b - box_t;
        core_top4 = 4 * box_t + h;
        core_bot4 = 4 * box_b + h;
        return (4 * band_bot > core_top4 + 4 * MARGIN) &&
               (4 * band_top < core_bot4 - 4 * MARGIN);
    endfunction

    function automatic bit segment_covers_core(longint px, longint py,
                                               longint qx, longint qy);
        longint cx2, xmin, xmax, ymin, ymax, dx, dy, e, q, y;
        bit     neg;
        cx2  = box_l + box_r;
        xmin = (px < qx) ? px : qx;
        xmax = (px < qx) ? qx : px;
        dx   = qx - px;
        dy   = qy - py;
        if (cx2 < 2 * xmin - 2 * HALF_PT || cx2 > 2 * xmax + 2 * HALF_PT)
            return 1'b0;
        if (abs_l(dx) < HALF_PT) begin
            ymin = (py < qy) ? py : qy;
            ymax = (py < qy) ? qy : py;
            return band_hits_core(ymin - half_w, ymax + half_w);
        end
        e   = cx2 - 2 * px;
        q   = (abs_l(dy) * abs_l(e)) / (2 * abs_l(dx));
        neg = ((dy < 0) != (e < 0)) != (dx < 0);
        if (dy == 0 || e == 0)
            neg = 1'b0;
        y = neg ? py - q : py + q;
        return band_hits_core(y - half_w, y + half_w);
    endfunction

    always @(posedge aclk) begin
        longint x, y;
        bit     want;
        if (!aresetn) begin
            box_l = 0; box_t = 0; box_r = 0; box_b = 0; half_w = 0;
            prev_x = 0; prev_y = 0;
            have_prev = 1'b0;
            hit_seen  = 1'b0;
            covered_due.delete();
            mismatch_cnt = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_CHAR_LEFT:   box_l  = longint'($signed(cfg_wdata[COORD_BITS-1:0]));
                    REG_CHAR_TOP:    box_t  = longint'($signed(cfg_wdata[COORD_BITS-1:0]));
                    REG_CHAR_RIGHT:  box_r  = longint'($signed(cfg_wdata[COORD_BITS-1:0]));
                    REG_CHAR_BOTTOM: box_b  = longint'($signed(cfg_wdata[COORD_BITS-1:0]));
                    REG_HALF_WIDTH:  half_w = longint'(cfg_wdata[HW_BITS-1:0]);
                    default: ;
                endcase
            end
            // compare before predicting: a word leaving now never stems from one entering now
            if (m_valid && m_ready) begin
                if (covered_due.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("covered word with none expected: got %0d", m_covered);
                end else begin
                    want = covered_due.pop_front();
                    if (m_covered !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("covered mismatch: expected %0d got %0d", want, m_covered);
                    end
                end
            end
            if (s_valid && s_ready) begin
                x = longint'(s_point_x);
                y = longint'(s_point_y);
                if (have_prev && segment_covers_core(prev_x, prev_y, x, y))
                    hit_seen = 1'b1;
                prev_x    = x;
                prev_y    = y;
                have_prev = 1'b1;
                if (s_last_point) begin
                    covered_due.insert(covered_due.size(), hit_seen);
                    have_prev = 1'b0;
                    hit_seen  = 1'b0;
                end
            end
        end
        pending    <= covered_due.size();
        fail_count <= mismatch_cnt + covered_due.size();
    end

endmodule

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the stroke coverage core.
// ---------------------------------------------------------------------------
// Drives directed strokes around a small box first, then random strokes over
// several box settings (normal, inverted, full-range extremes, random), with
// random gaps on both channels, stretches without gaps, and one long output
// hold-off that backs the core up into its input. The checker beside the core
// predicts and compares; this module only feeds it and reports the outcome.
module tb;
    import scct_pkg::*;

    localparam int COORD_BITS   = 18;
    localparam int CFG_BITS     = 18;
    localparam int COORD_MIN    = -131072;
    localparam int COORD_MAX    = 131071;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_POINTS = 120;
    localparam longint LIMIT_TIME = 64'd5_000_000;
    localparam logic [REG_IDX_BITS-1:0] REG_FIRST_UNUSED = REG_HALF_WIDTH + 1'b1;
    localparam logic [REG_IDX_BITS-1:0] REG_LAST_CODE    = '1;

    logic                          aclk         = 1'b0;
    logic                          aresetn      = 1'b0;
    logic                          cfg_we       = 1'b0;
    logic [REG_IDX_BITS-1:0]       cfg_index    = '0;
    logic [CFG_BITS-1:0]           cfg_wdata    = '0;
    logic                          s_valid      = 1'b0;
    logic                          s_ready;
    logic signed [COORD_BITS-1:0]  s_point_x    = '0;
    logic signed [COORD_BITS-1:0]  s_point_y    = '0;
    logic                          s_last_point = 1'b0;
    logic                          m_valid;
    logic                          m_ready      = 1'b0;
    logic                          m_covered;

    int fail_count;
    int pending;

    int tx_max_gap   = 0;
    int rx_max_stall = 0;
    bit hold_req     = 1'b0;
    int bl, bt, br, bb, bhw;

    stroke_covers_char_test_core #(.COORD_BITS(COORD_BITS)) dut (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_wdata,
        .s_valid, .s_ready, .s_point_x, .s_point_y, .s_last_point,
        .m_valid, .m_ready, .m_covered
    );

    stroke_cover_checker #(.COORD_BITS(COORD_BITS), .CFG_BITS(CFG_BITS)) chk (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_wdata,
        .s_valid, .s_ready, .s_point_x, .s_point_y, .s_last_point,
        .m_valid, .m_ready, .m_covered,
        .fail_count, .pending
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #(LIMIT_TIME);
        $display("FAILED: results differ");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        int n;
        bit held;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req && !held) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                held = 1'b1;
            end
            n = $urandom_range(0, rx_max_stall);
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    function automatic int clamp_coord(longint v);
        if (v < COORD_MIN) return COORD_MIN;
        if (v > COORD_MAX) return COORD_MAX;
        return int'(v);
    endfunction

    function automatic int rand_span(int s);
        return int'($urandom_range(0, 2 * s)) - s;
    endfunction

    task automatic send_point(int x, int y, bit last);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_point_x    <= COORD_BITS'(x);
        s_point_y    <= COORD_BITS'(y);
        s_last_point <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic cfg_write(logic [REG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_box(int l, int t, int r, int b, int hw);
        wait_drained();
        cfg_write(REG_CHAR_LEFT,   CFG_BITS'(l));
        cfg_write(REG_CHAR_TOP,    CFG_BITS'(t));
        cfg_write(REG_CHAR_RIGHT,  CFG_BITS'(r));
        cfg_write(REG_CHAR_BOTTOM, CFG_BITS'(b));
        cfg_write(REG_HALF_WIDTH,  {2'($urandom_range(0, 3)), 16'(hw)});
        cfg_write(3'($urandom_range(REG_FIRST_UNUSED, REG_LAST_CODE)),
                  CFG_BITS'($urandom));
        cfg_we <= 1'b0;
        bl = l; bt = t; br = r; bb = b; bhw = hw;
    endtask

    task automatic send_stroke(int npts);
        int  k, x, y, px, cx, cy, xs, ys;
        px = 0;
        cx = (bl + br) >>> 1;
        cy = (bt + bb) / 2 + (bb - bt) / 4;
        xs = clamp_coord((br > bl ? br - bl : bl - br) / 2 + 128);
        ys = clamp_coord((bb > bt ? bb - bt : bt - bb) / 2 + bhw + 64);
        for (k = 0; k < npts; k++) begin
            x = cx + rand_span(xs);
            y = cy + rand_span(ys);
            if (k > 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: x = px + rand_span(HALF_PT);
                    3: x = ($urandom_range(0, 1) ? cx + HALF_PT : cx - HALF_PT) + rand_span(1);
                    4: begin
                        x = int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
                        y = int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
                    end
                    default: ;
                endcase
            end
            x = clamp_coord(x);
            y = clamp_coord(y);
            send_point(x, y, k == npts - 1);
            px = x;
        end
    endtask

    task automatic random_phase(int npoints);
        int sent, n;
        sent = 0;
        while (sent < npoints) begin
            n = $urandom_range(1, 8);
            send_stroke(n);
            sent += n;
        end
    endtask

    initial begin
        int ph;
        bl = 0; bt = 0; br = 0; bb = 0; bhw = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset box: single point stroke, then a full-range diagonal
        send_point(0, 0, 1'b1);
        send_point(COORD_MIN, COORD_MIN, 1'b0);
        send_point(COORD_MAX, COORD_MAX, 1'b1);

        set_box(0, 0, 640, 1280, 64);
        send_point(320, 0, 1'b0);     send_point(330, 1000, 1'b1);   // upright
        send_point(0, 900, 1'b0);     send_point(640, 1000, 1'b1);   // sloped
        send_point(1000, 900, 1'b0);  send_point(1200, 900, 1'b1);   // x misses
        send_point(640, 1400, 1'b0);  send_point(0, 200, 1'b0);
        send_point(100, 100, 1'b1);                                  // falling dx
        send_point(320, 900, 1'b0);   send_point(1000, 5000, 1'b1);  // start at centre
        send_point(-500, 1500, 1'b0); send_point(800, 1500, 1'b1);   // flat
        send_point(0, 900, 1'b0);     send_point(288, 900, 1'b1);    // on window edge
        send_point(0, 900, 1'b0);     send_point(287, 900, 1'b1);    // just outside
        send_point(300, 5000, 1'b0);  send_point(331, -5000, 1'b1);  // upright, tall

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_box(-200, 500, 440, 1500, $urandom_range(0, 200));
                1: set_box(800, 3000, 100, 1800, $urandom_range(0, 400));
                2: set_box(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 65535);
                3: set_box(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 0);
                4: set_box(1000, -3000, 1400, -2000, $urandom_range(0, 300));
                default: begin
                    bl = int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
                    bt = int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
                    set_box(bl, bt, clamp_coord(bl + rand_span(2000)),
                            clamp_coord(bt + rand_span(3000)), $urandom_range(0, 65535));
                end
            endcase
            case (ph % 4)
                0: begin tx_max_gap = 5; rx_max_stall = 5; end
                1: begin tx_max_gap = 0; rx_max_stall = 0; end
                2: begin tx_max_gap = 5; rx_max_stall = 0; end
                default: begin tx_max_gap = 0; rx_max_stall = 5; end
            endcase
            if (ph == 4) begin
                tx_max_gap = 0;
                hold_req   = 1'b1;
                repeat (20) send_stroke(2);
            end
            random_phase(PHASE_POINTS);
        end

        wait_drained();
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/scct_pkg.sv
sv/scct_muldiv.sv
sv/scct_band_test.sv
sv/stroke_covers_char_test_core.sv
tb/stroke_cover_checker.sv
tb/tb.sv
